// ----- hw/rtl/abkf_pkg.sv -----
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter package
// Shared widths, constants, status codes and sequencer states.
// ----------------------------------------------------------------------------
package abkf_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int QBits    = 16;
  localparam int MagBits  = WordBits;
  localparam int ProdBits = 2 * MagBits;
  localparam int NumBits  = WordBits + FracBits;
  localparam int CntBits  = $clog2(ProdBits + 1);

  localparam logic signed [WordBits-1:0] MaxV = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] MinV = {1'b1, {(WordBits-1){1'b0}}};

  // Status codes of a result.
  localparam logic [1:0] StatCorrected = 2'd0;
  localparam logic [1:0] StatSkipped   = 2'd1;
  localparam logic [1:0] StatNoCorr    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] RegAngleQ  = 2'd0;
  localparam logic [1:0] RegBiasQ   = 2'd1;
  localparam logic [1:0] RegMeasure = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_PRED_A, S_PRED_A_ADD, S_PRED_D, S_PRED_T, S_PRED_P00,
    S_PRED_P11, S_PRED_S, S_DIV_K0, S_DIV_K1, S_CORR_Y, S_CORR_ANG,
    S_CORR_BIAS, S_CORR_P00, S_CORR_P01, S_CORR_P10, S_CORR_P11, S_OUT
  } state_t;

  // Saturating add of two words.
  function automatic logic signed [WordBits-1:0] add_sat(
      input logic signed [WordBits-1:0] a, input logic signed [WordBits-1:0] b);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) return s[WordBits] ? MinV : MaxV;
    return s[WordBits-1:0];
  endfunction

  // Saturating subtract of two words.
  function automatic logic signed [WordBits-1:0] sub_sat(
      input logic signed [WordBits-1:0] a, input logic signed [WordBits-1:0] b);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} - {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) return s[WordBits] ? MinV : MaxV;
    return s[WordBits-1:0];
  endfunction

  // Unsigned Q0.16 to the word format.
  function automatic logic signed [WordBits-1:0] from_q16(input logic [QBits-1:0] x);
    return WordBits'({x, {(FracBits-QBits){1'b0}}});
  endfunction

  // Unsigned magnitude of a word; the most negative value maps to 2^(WordBits-1).
  function automatic logic [MagBits-1:0] magn(input logic signed [WordBits-1:0] a);
    return a[WordBits-1] ? MagBits'(-a) : MagBits'(a);
  endfunction

endpackage

// ----- hw/rtl/abkf_serial_unit.sv -----
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter serial arithmetic unit
// Shift-and-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module abkf_serial_unit
  import abkf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       is_div,
  input  logic signed [WordBits-1:0] a,
  input  logic signed [WordBits-1:0] b,
  output logic                       done,
  output logic signed [WordBits-1:0] result
);

  logic                 busy;
  logic                 mode_div;
  logic                 neg;
  logic [CntBits-1:0]   count;
  logic [ProdBits-1:0]  acc;
  logic [MagBits-1:0]   mcand;
  logic [MagBits-1:0]   mplier;
  logic [NumBits-1:0]   numer;
  logic [MagBits:0]     rem;
  logic [NumBits-1:0]   quot;
  logic [MagBits:0]     rem_shift;
  logic [MagBits:0]     rem_diff;
  logic [ProdBits:0]    acc_sum;

  assign rem_shift = {rem[MagBits-1:0], numer[NumBits-1]};
  assign rem_diff  = rem_shift - {1'b0, mcand};
  assign acc_sum   = {1'b0, acc} + ({(ProdBits+1){mplier[0]}} &
                     {1'b0, mcand, {MagBits{1'b0}}});

  // One bit of the product or quotient per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        mode_div <= is_div;
        neg      <= a[WordBits-1] ^ (is_div ? 1'b0 : b[WordBits-1]);
        mcand    <= is_div ? MagBits'(b) : magn(b);
        mplier   <= magn(a);
        numer    <= {magn(a), {FracBits{1'b0}}};
        rem      <= '0;
        quot     <= '0;
        acc      <= '0;
        count    <= is_div ? CntBits'(NumBits) : CntBits'(MagBits);
      end else if (busy) begin
        if (mode_div) begin
          numer <= {numer[NumBits-2:0], 1'b0};
          if (!rem_diff[MagBits]) begin
            rem  <= rem_diff;
            quot <= {quot[NumBits-2:0], 1'b1};
          end else begin
            rem  <= rem_shift;
            quot <= {quot[NumBits-2:0], 1'b0};
          end
        end else begin
          acc    <= acc_sum[ProdBits:1];
          mplier <= {1'b0, mplier[MagBits-1:1]};
        end
        count <= count - 1'b1;
        if (count == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Rounding and saturation of the finished value.
  always_comb begin
    logic [NumBits:0] mag;
    logic             lost;
    if (mode_div) begin
      mag  = {1'b0, quot};
      lost = 1'b0;
    end else begin
      mag  = {1'b0, acc[ProdBits-1:FracBits]};
      lost = |acc[FracBits-1:0];
    end
    if (neg && lost) mag = mag + 1'b1;
    if (neg) begin
      if (mag > (NumBits+1)'({1'b1, {(WordBits-1){1'b0}}})) result = MinV;
      else result = WordBits'(-mag);
    end else begin
      if (mag > (NumBits+1)'(MaxV)) result = MaxV;
      else result = WordBits'(mag);
    end
  end

  // A finished operation is reported only after one was running.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("done without a running operation");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("start did not launch the unit");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("unit still busy when done");

endmodule

// ----- hw/rtl/angle_bias_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter
// Two-state filter that fuses an angle and a gyro rate into an angle estimate.
// ----------------------------------------------------------------------------
// Use: a request on the input channel (op, angle_in, rate_in, dt_in) gives
// exactly one result (angle_out, status) on the output channel. op one loads
// the angle and clears bias and covariance; a zero dt leaves the state alone.
// Both answer with status one. An update with correction runs ten
// multiplications and two divisions on one shared bit-serial unit, and one
// without correction runs four multiplications.
// One request is processed at a time: the next one is taken only once the
// result has been accepted and the block is idle, so a stalling receiver
// holds off the input channel.
// Reset clears the state and loads the noise registers with their defaults.
// The configuration port writes a noise register at any time the block
// is idle.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter
  import abkf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic signed [31:0]  angle_in,
  input  logic signed [31:0]  rate_in,
  input  logic [15:0]         dt_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  angle_out,
  output logic [1:0]          status,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  state_t state, state_next;

  logic [QBits-1:0] q_angle, q_bias, r_meas;
  logic signed [WordBits-1:0] angle_est, bias_est, p00, p01, p10, p11;
  logic signed [WordBits-1:0] meas, dt, tmp, dval, k0, k1, y, s_sum;
  logic signed [WordBits-1:0] p00o, p01o;

  logic                       mu_start, mu_div, mu_done;
  logic signed [WordBits-1:0] mu_a, mu_b, mu_res;
  logic                       launched;

  abkf_serial_unit u_unit (
    .clk(clk), .rst(rst), .start(mu_start), .is_div(mu_div),
    .a(mu_a), .b(mu_b), .done(mu_done), .result(mu_res)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= 16'd66;
      q_bias  <= 16'd197;
      r_meas  <= 16'd1966;
    end else if (cfg_we) begin
      case (cfg_index)
        RegAngleQ:  q_angle <= cfg_data;
        RegBiasQ:   q_bias  <= cfg_data;
        RegMeasure: r_meas  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:
        if (in_valid && in_ready)
          state_next = (op || dt_in == '0) ? S_OUT : S_PRED_A;
      S_PRED_A:     if (mu_done) state_next = S_PRED_A_ADD;
      S_PRED_A_ADD: state_next = S_PRED_D;
      S_PRED_D:     if (mu_done) state_next = S_PRED_T;
      S_PRED_T:     state_next = S_PRED_P00;
      S_PRED_P00:   if (mu_done) state_next = S_PRED_P11;
      S_PRED_P11:   if (mu_done) state_next = S_PRED_S;
      S_PRED_S:     state_next = (s_sum[WordBits-1] || s_sum == '0) ? S_OUT : S_DIV_K0;
      S_DIV_K0:     if (mu_done) state_next = S_DIV_K1;
      S_DIV_K1:     if (mu_done) state_next = S_CORR_Y;
      S_CORR_Y:     state_next = S_CORR_ANG;
      S_CORR_ANG:   if (mu_done) state_next = S_CORR_BIAS;
      S_CORR_BIAS:  if (mu_done) state_next = S_CORR_P00;
      S_CORR_P00:   if (mu_done) state_next = S_CORR_P01;
      S_CORR_P01:   if (mu_done) state_next = S_CORR_P10;
      S_CORR_P10:   if (mu_done) state_next = S_CORR_P11;
      S_CORR_P11:   if (mu_done) state_next = S_OUT;
      S_OUT:        state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    mu_div = 1'b0;
    mu_a   = dt;
    mu_b   = tmp;
    case (state)
      S_PRED_A:    begin mu_a = dt;  mu_b = tmp;  end
      S_PRED_D:    begin mu_a = dt;  mu_b = p11;  end
      S_PRED_P00:  begin mu_a = dt;  mu_b = tmp;  end
      S_PRED_P11:  begin mu_a = from_q16(q_bias); mu_b = dt; end
      S_DIV_K0:    begin mu_div = 1'b1; mu_a = p00; mu_b = s_sum; end
      S_DIV_K1:    begin mu_div = 1'b1; mu_a = p10; mu_b = s_sum; end
      S_CORR_ANG:  begin mu_a = k0;  mu_b = y;    end
      S_CORR_BIAS: begin mu_a = k1;  mu_b = y;    end
      S_CORR_P00:  begin mu_a = k0;  mu_b = p00o; end
      S_CORR_P01:  begin mu_a = k0;  mu_b = p01o; end
      S_CORR_P10:  begin mu_a = k1;  mu_b = p00o; end
      S_CORR_P11:  begin mu_a = k1;  mu_b = p01o; end
      default: ;
    endcase
  end

  assign mu_start = !launched && state != S_IDLE && state != S_OUT &&
                    state != S_PRED_A_ADD && state != S_PRED_T &&
                    state != S_PRED_S && state != S_CORR_Y;

  // State registers and datapath updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      angle_est <= '0;
      bias_est  <= '0;
      p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
    end else begin
      state <= state_next;
      if (mu_start) launched <= 1'b1;
      if (mu_done)  launched <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:
          if (in_valid && in_ready) begin
            meas   <= angle_in;
            dt     <= from_q16(dt_in);
            tmp    <= sub_sat(rate_in, bias_est);
            status <= StatSkipped;
            if (op) begin
              angle_est <= angle_in;
              bias_est  <= '0;
              p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
            end
          end
        S_PRED_A:     if (mu_done) tmp <= mu_res;
        S_PRED_A_ADD: angle_est <= add_sat(angle_est, tmp);
        S_PRED_D:     if (mu_done) dval <= mu_res;
        S_PRED_T:
          tmp <= add_sat(sub_sat(sub_sat(dval, p01), p10), from_q16(q_angle));
        S_PRED_P00:
          if (mu_done) begin
            p00 <= add_sat(p00, mu_res);
            p01 <= sub_sat(p01, dval);
            p10 <= sub_sat(p10, dval);
          end
        S_PRED_P11:
          if (mu_done) begin
            p11   <= add_sat(p11, mu_res);
            s_sum <= add_sat(p00, from_q16(r_meas));
          end
        S_PRED_S: status <= StatNoCorr;
        S_DIV_K0: if (mu_done) k0 <= mu_res;
        S_DIV_K1: if (mu_done) k1 <= mu_res;
        S_CORR_Y: begin
          y    <= sub_sat(meas, angle_est);
          p00o <= p00;
          p01o <= p01;
        end
        S_CORR_ANG:  if (mu_done) angle_est <= add_sat(angle_est, mu_res);
        S_CORR_BIAS: if (mu_done) bias_est <= add_sat(bias_est, mu_res);
        S_CORR_P00:  if (mu_done) p00 <= sub_sat(p00, mu_res);
        S_CORR_P01:  if (mu_done) p01 <= sub_sat(p01, mu_res);
        S_CORR_P10:  if (mu_done) p10 <= sub_sat(p10, mu_res);
        S_CORR_P11:
          if (mu_done) begin
            p11    <= sub_sat(p11, mu_res);
            status <= StatCorrected;
          end
        S_OUT: begin
          out_valid <= 1'b1;
          angle_out <= angle_est;
        end
        default: ;
      endcase
    end
  end

  // A result appears only at the end of an item's work.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output step");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid)
    else $error("request taken while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == StatCorrected || status == StatSkipped ||
                   status == StatNoCorr))
    else $error("undefined status code");

endmodule

// ----- tb/abkf_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter checker
// Watches the request and result channels and the register port, runs its
// own fixed-point model of the filter on each accepted request, and compares
// every accepted result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module abkf_checker
  import abkf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic signed [31:0] angle_in,
  input  logic signed [31:0] rate_in,
  input  logic [15:0]        dt_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] angle_out,
  input  logic [1:0]         status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count,
  output int                 corrected_count
);

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic [1:0]         stat;
  } estimate_t;

  estimate_t   estimate_q[$];
  logic [15:0] q_angle, q_bias, r_meas;
  word_t       ang, bias, p00, p01, p10, p11;

  // Clamp a wide value to the word range.
  function automatic word_t clamp_word(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -128'sh8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clamp_word(wa + wb);
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clamp_word(wa - wb);
  endfunction

  // Product shifted down by the fraction bits; the arithmetic shift floors.
  function automatic word_t fix_mul(input word_t a, input word_t b);
    logic signed [127:0] wa, wb, pr;
    wa = a;
    wb = b;
    pr = wa * wb;
    return clamp_word(pr >>> 16);
  endfunction

  // Gain (p << 16) / s with s positive, truncating toward zero.
  function automatic word_t fix_div(input word_t p, input word_t s);
    logic signed [127:0] num, den;
    num = p;
    num = num * 65536;
    den = s;
    return clamp_word(num / den);
  endfunction

  function automatic word_t from_frac(input logic [15:0] x);
    return {16'd0, x};
  endfunction

  // One filter step on the model state.
  task automatic model_step(input logic o, input word_t meas, input word_t rate,
                            input logic [15:0] dt_raw);
    word_t dt, t, d, s, k0, k1, y, p00o, p01o;
    estimate_t e;
    if (o) begin
      ang = meas;
      bias = 0;
      p00 = 0; p01 = 0; p10 = 0; p11 = 0;
      e.stat = StatSkipped;
    end else if (dt_raw == 0) begin
      e.stat = StatSkipped;
    end else begin
      dt = from_frac(dt_raw);
      ang = sat_add(ang, fix_mul(dt, sat_sub(rate, bias)));
      t = sat_sub(fix_mul(dt, p11), p01);
      t = sat_sub(t, p10);
      t = sat_add(t, from_frac(q_angle));
      p00 = sat_add(p00, fix_mul(dt, t));
      d = fix_mul(dt, p11);
      p01 = sat_sub(p01, d);
      p10 = sat_sub(p10, d);
      p11 = sat_add(p11, fix_mul(from_frac(q_bias), dt));
      s = sat_add(p00, from_frac(r_meas));
      if (s <= 0) begin
        e.stat = StatNoCorr;
      end else begin
        k0 = fix_div(p00, s);
        k1 = fix_div(p10, s);
        y = sat_sub(meas, ang);
        ang = sat_add(ang, fix_mul(k0, y));
        bias = sat_add(bias, fix_mul(k1, y));
        p00o = p00;
        p01o = p01;
        p00 = sat_sub(p00, fix_mul(k0, p00o));
        p01 = sat_sub(p01, fix_mul(k0, p01o));
        p10 = sat_sub(p10, fix_mul(k1, p00o));
        p11 = sat_sub(p11, fix_mul(k1, p01o));
        e.stat = StatCorrected;
      end
    end
    e.angle = ang;
    estimate_q.push_back(e);
  endtask

  // Sample all channels at the clock edge and update the model.
  always @(posedge clk) begin
    estimate_t e;
    if (rst) begin
      q_angle = 16'd66;
      q_bias  = 16'd197;
      r_meas  = 16'd1966;
      ang = 0; bias = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
      estimate_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegAngleQ:  q_angle = cfg_data;
          RegBiasQ:   q_bias  = cfg_data;
          RegMeasure: r_meas  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (estimate_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result angle=%0d status=%0d", $time,
                   angle_out, status);
        end else begin
          e = estimate_q.pop_front();
          if (e.stat == StatCorrected) corrected_count++;
          if (angle_out !== e.angle) begin
            fail_count++;
            $display("%0t: angle_out expected %0d actual %0d", $time, e.angle,
                     angle_out);
          end
          if (status !== e.stat) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, e.stat,
                     status);
          end
        end
      end
      if (in_valid && in_ready) model_step(op, angle_in, rate_in, dt_in);
    end
    pending = estimate_q.size();
  end

endmodule

// ----- tb/tb_angle_bias_kalman_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter testbench
// Drives directed and random requests and register settings through several
// idling phases; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_angle_bias_kalman_filter;
  import abkf_pkg::*;

  localparam int CycleLimit = 4_000_000;

  logic               clk, rst;
  logic               in_valid, in_ready, op;
  logic signed [31:0] angle_in, rate_in;
  logic [15:0]        dt_in;
  logic               out_valid, out_ready;
  logic signed [31:0] angle_out;
  logic [1:0]         status;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count, pending, result_count, corrected_count;
  int                 send_idle_pct, stall_pct, cycles;

  angle_bias_kalman_filter u_dut (.*);

  abkf_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random with the current phase's rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one request and wait until it is accepted; valid drops only while
  // the sender idles.
  task automatic send_request(input logic o, input logic [31:0] a,
                              input logic [31:0] r, input logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    angle_in <= a;
    rate_in <= r;
    dt_in <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every result, then let the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  // Mostly plausible sensor samples, with some extremes and resets.
  task automatic random_block(input int n);
    logic [31:0] a, r;
    logic [15:0] dt;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      a = rand_word(pick < 8 ? $urandom_range(2) : 3);
      r = rand_word(pick > 92 ? $urandom_range(2) : 3);
      case ($urandom_range(9))
        0: dt = 16'd0;
        1: dt = 16'($urandom());
        2: dt = 16'hFFFF;
        default: dt = 16'($urandom_range(1, 1000));
      endcase
      send_request(pick < 3, a, r, dt);
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0; op = 0; angle_in = 0; rate_in = 0; dt_in = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    send_idle_pct = 0; stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: resets, zero dt, extremes, full dt, and a zero s.
    send_request(1'b0, 32'h0001_0000, 32'h0000_8000, 16'd655);
    send_request(1'b0, 32'h0001_0000, 32'h0000_8000, 16'd0);
    send_request(1'b1, 32'h7FFF_FFFF, 32'h0, 16'd100);
    send_request(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    send_request(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_request(1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(1'b0, 32'h8000_0000, 32'h8000_0000, 16'd1);
    send_request(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
    send_request(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
    send_request(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
    drain();
    write_reg(RegAngleQ, 16'd0);
    write_reg(RegBiasQ, 16'd0);
    write_reg(RegMeasure, 16'd0);
    send_request(1'b1, 32'h0, 32'h0, 16'd0);
    // With P and R both zero the correction is skipped.
    send_request(1'b0, 32'h0001_0000, 32'h0001_0000, 16'd100);
    send_request(1'b0, 32'h0001_0000, 32'h0001_0000, 16'hFFFF);
    drain();
    write_reg(RegAngleQ, 16'hFFFF);
    write_reg(RegBiasQ, 16'hFFFF);
    write_reg(RegMeasure, 16'hFFFF);
    send_request(1'b0, 32'h0010_0000, 32'hFFF0_0000, 16'hFFFF);
    send_request(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    drain();

    // Random phases over idling patterns and register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      if (ph == 4) begin
        write_reg(RegAngleQ, 16'd66);
        write_reg(RegBiasQ, 16'd197);
        write_reg(RegMeasure, 16'd1966);
      end else begin
        write_reg(RegAngleQ, 16'($urandom()));
        write_reg(RegBiasQ, 16'($urandom_range(2000)));
        write_reg(RegMeasure, ph == 7 ? 16'd0 : 16'($urandom()));
      end
      random_block(235);
      drain();
    end

    $display("Run covered %0d results, %0d with correction, over 8 idling phases.",
             result_count, corrected_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
